// ----- rtl/jlms_pkg.sv -----
package jlms_pkg;

    // field widths
    localparam int VAL_W  = 32;
    localparam int LIM_W  = 31;
    localparam int TIME_W = 20;
    localparam int PH_W   = 3;
    localparam int ACT_W  = 2;

    // digit-serial time multiplier geometry
    localparam int DIGIT     = 4;
    localparam int DT_DIGITS = TIME_W / DIGIT;
    localparam int CNT_W     = $clog2(DT_DIGITS);
    localparam int OPND_W    = VAL_W + 1;
    localparam int PROD_W    = VAL_W + TIME_W + 1;
    localparam int SAT_W     = PROD_W + 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

    // motion phases
    localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PH_W-1:0] PH_JERK_UP   = 3'd1;
    localparam logic [PH_W-1:0] PH_CONST_ACC = 3'd2;
    localparam logic [PH_W-1:0] PH_JERK_DOWN = 3'd3;
    localparam logic [PH_W-1:0] PH_CRUISE    = 3'd4;
    localparam logic [PH_W-1:0] PH_DEC_START = 3'd5;
    localparam logic [PH_W-1:0] PH_CONST_DEC = 3'd6;
    localparam logic [PH_W-1:0] PH_DEC_END   = 3'd7;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JERK        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ACCEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_END_VEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_END_VEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_DIST    = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] time_step;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] position;
        logic signed [VAL_W-1:0] velocity;
        logic signed [VAL_W-1:0] acceleration;
        logic [PH_W-1:0]         phase;
        logic                    moving;
    } out_t;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

    // clamp to the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] y;
        begin
            if (x > SAT_HI)
            begin
                y = SAT_HI;
            end
            else if (x < SAT_LO)
            begin
                y = SAT_LO;
            end
            else
            begin
                y = x;
            end
            return $signed(y[VAL_W-1:0]);
        end
    endfunction

endpackage

// ----- rtl/jlms_time_mul.sv -----
module jlms_time_mul #(
    parameter int TIME_FRAC_BITS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [jlms_pkg::OPND_W-1:0] operand,
    input  logic [jlms_pkg::TIME_W-1:0]        time_step,
    output logic                               done,
    output logic signed [jlms_pkg::VAL_W-1:0]  result
);
    import jlms_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [TIME_W-1:0]        dt_sr_reg;

    logic signed [PROD_W+DIGIT:0] partial;
    logic signed [PROD_W-1:0]     shifted;

    // one time digit per cycle, LSB first
    assign partial = mcand_reg * $signed({1'b0, dt_sr_reg[DIGIT-1:0]});
    // arithmetic shift floors toward minus infinity
    assign shifted = prod_reg >>> TIME_FRAC_BITS;
    assign result  = sat32(SAT_W'(shifted));
    assign done    = done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DT_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: multiplicand shifts up a digit, time shifts down a digit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= PROD_W'(operand);
            prod_reg  <= '0;
            dt_sr_reg <= time_step;
        end
        else if (busy_reg)
        begin
            prod_reg  <= prod_reg + partial[PROD_W-1:0];
            mcand_reg <= mcand_reg <<< DIGIT;
            dt_sr_reg <= dt_sr_reg >> DIGIT;
        end
    end

endmodule

// ----- rtl/jerk_limited_motion_profile_stepper.sv -----
// Jerk-limited S-curve stepper. Each input beat is a tick, a start, a stop or an unknown
// action; each one yields exactly one output beat with position, velocity, acceleration
// and phase after the step. Start, stop, unknown actions and ticks while idle go from
// accept straight to the done state, which puts the result out once the output register
// is free. A tick while moving runs its products through one shared time multiplier
// (jerk*dt, accel*dt, velocity*dt), each scanning the 20-bit time step four bits a cycle.
// When the phase changes, or in cruise, accel*dt is skipped. A new beat is taken only once
// the block is back in idle, but also while a finished result still waits at the output.
// Profile registers must be written by the user only while the block is idle; the block
// itself does not enforce this.
module jerk_limited_motion_profile_stepper #(
    parameter int TIME_FRAC_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [jlms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jlms_pkg::VAL_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  jlms_pkg::in_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output jlms_pkg::out_t                        out_data
);
    import jlms_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_JERK  = 5'b00010,
        ST_ACCEL = 5'b00100,
        ST_VEL   = 5'b01000,
        ST_DONE  = 5'b10000
    } seq_state_t;

    // profile registers
    logic signed [VAL_W-1:0] target_reg;
    logic [LIM_W-1:0]        jerk_reg;
    logic [LIM_W-1:0]        peak_accel_reg;
    logic [LIM_W-1:0]        acc_end_vel_reg;
    logic signed [VAL_W-1:0] peak_decel_reg;
    logic [LIM_W-1:0]        dec_end_vel_reg;
    logic [LIM_W-1:0]        dec_dist_reg;

    // motion state
    seq_state_t              state_reg, state_next;
    logic [PH_W-1:0]         phase_reg, phase_next;
    logic signed [VAL_W-1:0] pos_reg, pos_next;
    logic signed [VAL_W-1:0] vel_reg, vel_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [TIME_W-1:0]       dt_reg, dt_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_data_reg, out_data_next;

    // multiplier hookup
    logic                     mul_start;
    logic signed [OPND_W-1:0] mul_operand;
    logic                     mul_done;
    logic signed [VAL_W-1:0]  mul_result;

    // phase exit tests and ramp arithmetic
    logic signed [VAL_W:0]   acc33, vel33, pos33, tgt33, tp_diff;
    logic [VAL_W:0]          tp_mag;
    logic [VAL_W-1:0]        acc_mag, pdec_mag, pos_mag, tgt_mag;
    logic                    ramp_down;
    logic signed [VAL_W:0]   ramp_sum, vel_sum, dp_neg, pos_sum;
    logic signed [VAL_W-1:0] ramp_acc, dp_dir;
    logic                    c_peak, c_acc_end, c_zero, c_dist, c_pdec, c_dec_end, c_finish;

    function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
        return x[VAL_W-1] ? (~x + 1'b1) : x;
    endfunction

    // time step taken from dt_next so the first product sees the beat just accepted
    jlms_time_mul #(
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .operand  (mul_operand),
        .time_step(dt_next),
        .done     (mul_done),
        .result   (mul_result)
    );

    assign acc33   = {acc_reg[VAL_W-1], acc_reg};
    assign vel33   = {vel_reg[VAL_W-1], vel_reg};
    assign pos33   = {pos_reg[VAL_W-1], pos_reg};
    assign tgt33   = {target_reg[VAL_W-1], target_reg};
    assign tp_diff = tgt33 - pos33;
    assign tp_mag  = tp_diff[VAL_W] ? (~tp_diff + 1'b1) : tp_diff;
    assign acc_mag  = mag32(acc_reg);
    assign pdec_mag = mag32(peak_decel_reg);
    assign pos_mag  = mag32(pos_reg);
    assign tgt_mag  = mag32(target_reg);

    assign c_peak    = acc33 >= $signed({2'b00, peak_accel_reg});
    assign c_acc_end = vel33 >= $signed({2'b00, acc_end_vel_reg});
    assign c_zero    = acc_reg <= 0;
    assign c_dist    = tp_mag <= {2'b00, dec_dist_reg};
    assign c_pdec    = acc_mag > pdec_mag;
    assign c_dec_end = vel33 <= $signed({2'b00, dec_end_vel_reg});
    assign c_finish  = (pos_mag >= tgt_mag) || vel_reg[VAL_W-1];

    // jerk adds in jerk-up and decel-end, subtracts in jerk-down and decel-start
    assign ramp_down = (phase_reg == PH_JERK_DOWN) || (phase_reg == PH_DEC_START);
    assign ramp_sum  = ramp_down ? acc33 - {mul_result[VAL_W-1], mul_result}
                                 : acc33 + {mul_result[VAL_W-1], mul_result};
    assign ramp_acc  = sat32(SAT_W'(ramp_sum));

    // velocity and position updates from the product
    assign vel_sum = vel33 + {mul_result[VAL_W-1], mul_result};
    assign dp_neg  = -{mul_result[VAL_W-1], mul_result};
    assign dp_dir  = neg_reg ? sat32(SAT_W'(dp_neg)) : mul_result;
    assign pos_sum = pos33 + {dp_dir[VAL_W-1], dp_dir};

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        dt_next        = dt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        mul_operand    = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DONE;
                    case (in_data.action)
                        ACT_TICK:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                dt_next    = in_data.time_step;
                                mul_start  = 1'b1;
                                state_next = ST_JERK;
                            end
                        end
                        ACT_START:
                        begin
                            neg_next   = tp_diff[VAL_W];
                            phase_next = PH_JERK_UP;
                        end
                        ACT_STOP:
                        begin
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_JERK:
            begin
                // jerk*dt ready: test the phase exit, then ramp, hold or switch
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_VEL;
                    case (phase_reg)
                        PH_JERK_UP:
                        begin
                            if (c_peak)
                            begin
                                acc_next   = $signed({1'b0, peak_accel_reg});
                                phase_next = PH_CONST_ACC;
                            end
                            else
                            begin
                                acc_next   = ramp_acc;
                                state_next = ST_ACCEL;
                            end
                        end
                        PH_CONST_ACC:
                        begin
                            if (c_acc_end)
                            begin
                                phase_next = PH_JERK_DOWN;
                            end
                            else
                            begin
                                state_next = ST_ACCEL;
                            end
                        end
                        PH_JERK_DOWN:
                        begin
                            if (c_zero)
                            begin
                                acc_next   = '0;
                                phase_next = PH_CRUISE;
                            end
                            else
                            begin
                                acc_next   = ramp_acc;
                                state_next = ST_ACCEL;
                            end
                        end
                        PH_CRUISE:
                        begin
                            if (c_dist)
                            begin
                                phase_next = PH_DEC_START;
                            end
                        end
                        PH_DEC_START:
                        begin
                            if (c_pdec)
                            begin
                                acc_next   = peak_decel_reg;
                                phase_next = PH_CONST_DEC;
                            end
                            else
                            begin
                                acc_next   = ramp_acc;
                                state_next = ST_ACCEL;
                            end
                        end
                        PH_CONST_DEC:
                        begin
                            if (c_dec_end)
                            begin
                                phase_next = PH_DEC_END;
                            end
                            else
                            begin
                                state_next = ST_ACCEL;
                            end
                        end
                        default:
                        begin
                            // decel end: snap to the target once reached or once velocity turns negative
                            if (c_finish)
                            begin
                                vel_next   = '0;
                                acc_next   = '0;
                                pos_next   = target_reg;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                acc_next   = ramp_acc;
                                state_next = ST_ACCEL;
                            end
                        end
                    endcase
                end
            end

            ST_ACCEL:
            begin
                if (mul_done)
                begin
                    vel_next   = sat32(SAT_W'(vel_sum));
                    mul_start  = 1'b1;
                    state_next = ST_VEL;
                end
            end

            ST_VEL:
            begin
                if (mul_done)
                begin
                    pos_next   = sat32(SAT_W'(pos_sum));
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.position     = pos_reg;
                    out_data_next.velocity     = vel_reg;
                    out_data_next.acceleration = acc_reg;
                    out_data_next.phase        = phase_reg;
                    out_data_next.moving       = (phase_reg != PH_IDLE);
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // multiplier operand follows the step being launched
        if (mul_start)
        begin
            if (state_next == ST_ACCEL)
            begin
                mul_operand = OPND_W'(acc_next);
            end
            else if (state_next == ST_VEL)
            begin
                mul_operand = OPND_W'(vel_next);
            end
            else
            begin
                mul_operand = {2'b00, jerk_reg};
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            vel_reg       <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        out_data_reg <= out_data_next;
    end

    // profile register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            jerk_reg        <= '0;
            peak_accel_reg  <= '0;
            acc_end_vel_reg <= '0;
            peak_decel_reg  <= '0;
            dec_end_vel_reg <= '0;
            dec_dist_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET:      target_reg      <= $signed(cfg_data);
                REG_JERK:        jerk_reg        <= cfg_data[LIM_W-1:0];
                REG_PEAK_ACCEL:  peak_accel_reg  <= cfg_data[LIM_W-1:0];
                REG_ACC_END_VEL: acc_end_vel_reg <= cfg_data[LIM_W-1:0];
                REG_PEAK_DECEL:  peak_decel_reg  <= $signed(cfg_data);
                REG_DEC_END_VEL: dec_end_vel_reg <= cfg_data[LIM_W-1:0];
                REG_DEC_DIST:    dec_dist_reg    <= cfg_data[LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_jerk_limited_motion_profile_stepper.sv -----
`timescale 1ns / 100ps

module tb_jerk_limited_motion_profile_stepper;

    import jlms_pkg::*;

    localparam int     TFB          = 20;
    localparam longint UNIT         = 64'sd65536;
    localparam longint VAL_MAX      = 64'sd2147483647;
    localparam longint VAL_MIN      = -64'sd2147483648;
    localparam int     QUIET_LIMIT  = 5000;
    localparam int     SETTLE       = 40;
    localparam int     ITEMS_TOTAL  = 850;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // Tracks the profile state, predicts each output beat and checks it
    class motion_tracker;
        longint target_pos, jerk, pk_accel, acc_end_vel;
        longint pk_decel, dec_end_vel, dec_dist;
        logic [PH_W-1:0] phase;
        longint pos, vel, acc;
        bit     neg;
        out_t   expected_samples[$];
        int     error_count;

        function new();
            target_pos = 0; jerk = 0; pk_accel = 0; acc_end_vel = 0;
            pk_decel = 0; dec_end_vel = 0; dec_dist = 0;
            phase = PH_IDLE;
            pos = 0; vel = 0; acc = 0;
            neg = 1'b0;
            error_count = 0;
        endfunction

        function longint clamp32(longint x);
            if (x > VAL_MAX)
                return VAL_MAX;
            if (x < VAL_MIN)
                return VAL_MIN;
            return x;
        endfunction

        function longint mag(longint x);
            return (x < 0) ? -x : x;
        endfunction

        // value * dt in Q0.20, floored, saturated
        function longint scale_by_time(longint v, longint dt);
            longint p;
            p = v * dt;
            return clamp32(p >>> TFB);
        endfunction

        function void ramp(longint jdt, longint dt);
            acc = clamp32(acc + jdt);
            vel = clamp32(vel + scale_by_time(acc, dt));
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                REG_TARGET:      target_pos  = longint'($signed(data));
                REG_JERK:        jerk        = longint'(data[LIM_W-1:0]);
                REG_PEAK_ACCEL:  pk_accel    = longint'(data[LIM_W-1:0]);
                REG_ACC_END_VEL: acc_end_vel = longint'(data[LIM_W-1:0]);
                REG_PEAK_DECEL:  pk_decel    = longint'($signed(data));
                REG_DEC_END_VEL: dec_end_vel = longint'(data[LIM_W-1:0]);
                REG_DEC_DIST:    dec_dist    = longint'(data[LIM_W-1:0]);
                default: ;
            endcase
        endfunction

        // one moving tick: phase exit test or integration, then position
        function void advance_motion(longint dt);
            longint jdt, dp;
            jdt = scale_by_time(jerk, dt);
            case (phase)
                PH_JERK_UP:
                    if (acc >= pk_accel)
                    begin
                        acc   = pk_accel;
                        phase = PH_CONST_ACC;
                    end
                    else
                        ramp(jdt, dt);
                PH_CONST_ACC:
                    if (vel >= acc_end_vel)
                        phase = PH_JERK_DOWN;
                    else
                        vel = clamp32(vel + scale_by_time(acc, dt));
                PH_JERK_DOWN:
                    if (acc <= 0)
                    begin
                        acc   = 0;
                        phase = PH_CRUISE;
                    end
                    else
                        ramp(-jdt, dt);
                PH_CRUISE:
                    if (mag(target_pos - pos) <= dec_dist)
                        phase = PH_DEC_START;
                PH_DEC_START:
                    if (mag(acc) > mag(pk_decel))
                    begin
                        acc   = pk_decel;
                        phase = PH_CONST_DEC;
                    end
                    else
                        ramp(-jdt, dt);
                PH_CONST_DEC:
                    if (vel <= dec_end_vel)
                        phase = PH_DEC_END;
                    else
                        vel = clamp32(vel + scale_by_time(acc, dt));
                default:
                    // final phase: snap to target once reached or reversed
                    if (mag(pos) >= mag(target_pos) || vel < 0)
                    begin
                        vel   = 0;
                        acc   = 0;
                        pos   = target_pos;
                        phase = PH_IDLE;
                    end
                    else
                        ramp(jdt, dt);
            endcase
            dp = scale_by_time(vel, dt);
            if (neg)
                dp = clamp32(-dp);
            pos = clamp32(pos + dp);
        endfunction

        // accepted input beat: update state, queue the expected output beat
        function void note_command(in_t beat);
            out_t exp_beat;
            if (beat.action == ACT_TICK)
            begin
                if (phase != PH_IDLE)
                    advance_motion(longint'(beat.time_step));
            end
            else if (beat.action == ACT_START)
            begin
                neg   = (target_pos - pos) < 0;
                phase = PH_JERK_UP;
            end
            else if (beat.action == ACT_STOP)
                phase = PH_IDLE;
            exp_beat.position     = pos[VAL_W-1:0];
            exp_beat.velocity     = vel[VAL_W-1:0];
            exp_beat.acceleration = acc[VAL_W-1:0];
            exp_beat.phase        = phase;
            exp_beat.moving       = (phase != PH_IDLE);
            expected_samples = {expected_samples, exp_beat};
        endfunction

        task report(string what, longint got, longint want);
            error_count++;
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        endtask

        task check_sample(out_t got);
            out_t want;
            if (expected_samples.size() == 0)
            begin
                report("unexpected output beat", 0, 0);
                return;
            end
            want = expected_samples.pop_front();
            if (got.position !== want.position)
                report("position", got.position, want.position);
            if (got.velocity !== want.velocity)
                report("velocity", got.velocity, want.velocity);
            if (got.acceleration !== want.acceleration)
                report("acceleration", got.acceleration, want.acceleration);
            if (got.phase !== want.phase)
                report("phase", got.phase, want.phase);
            if (got.moving !== want.moving)
                report("moving", got.moving, want.moving);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_t                 out_data;

    motion_tracker sb;
    int            send_gap_pct;
    int            recv_stall_pct;
    int            items_sent;
    int            quiet_cycles;

    jerk_limited_motion_profile_stepper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: register writes, accepted beats, output beat checks, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_write)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                sb.note_command(in_data);
                quiet_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                sb.check_sample(out_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("jerk_limited_motion_profile_stepper regression: fail");
                $finish;
            end
        end
    end

    // one input beat, with an optional random gap ahead of it
    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] dt);
        in_t beat;
        beat.action    = act;
        beat.time_step = dt;
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // stop sending and let every expected beat come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_dt();
        if ($urandom_range(19) == 0)
            return TIME_W'($urandom_range(20'hFFFFF, 0));
        return TIME_W'($urandom_range(1 << 18, 1 << 15));
    endfunction

    // one move: a fresh profile, start, ticks with some noise, stop
    task automatic run_motion();
        longint acc_pk, span, tgt;
        int     n_ticks, pick;
        wait_drained();
        if ($urandom_range(5) == 0)
        begin
            write_reg(REG_TARGET,      $urandom());
            write_reg(REG_JERK,        $urandom());
            write_reg(REG_PEAK_ACCEL,  $urandom());
            write_reg(REG_ACC_END_VEL, $urandom());
            write_reg(REG_PEAK_DECEL,  $urandom());
            write_reg(REG_DEC_END_VEL, $urandom());
            write_reg(REG_DEC_DIST,    $urandom());
        end
        else
        begin
            // coherent profile so that the moves walk through every phase
            acc_pk = longint'($urandom_range(20, 2)) * UNIT;
            span   = longint'($urandom_range(400, 20)) * UNIT;
            tgt    = $urandom_range(1) ? sb.pos + span : sb.pos - span;
            write_reg(REG_TARGET,      VAL_W'(sb.clamp32(tgt)));
            write_reg(REG_JERK,        VAL_W'(acc_pk * longint'($urandom_range(8, 2))));
            write_reg(REG_PEAK_ACCEL,  VAL_W'(acc_pk));
            write_reg(REG_ACC_END_VEL, VAL_W'(acc_pk * longint'($urandom_range(3, 1)) / 2));
            write_reg(REG_PEAK_DECEL,  VAL_W'(-acc_pk * longint'($urandom_range(3, 1)) / 2));
            write_reg(REG_DEC_END_VEL, VAL_W'(longint'($urandom_range(2, 0)) * UNIT));
            write_reg(REG_DEC_DIST,    VAL_W'(span * longint'($urandom_range(50, 10)) / 100));
        end
        cfg_write <= 1'b0;
        send_cmd(ACT_START, TIME_W'($urandom()));
        n_ticks = $urandom_range(70, 20);
        repeat (n_ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_cmd(ACT_STOP, TIME_W'($urandom()));
            else if (pick < 4)
                send_cmd(ACT_START, TIME_W'($urandom()));
            else if (pick < 6)
                send_cmd(ACT_UNUSED, TIME_W'($urandom()));
            else
                send_cmd(ACT_TICK, pick_dt());
        end
        send_cmd(ACT_STOP, TIME_W'($urandom()));
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        send_gap_pct   = 21;
        recv_stall_pct = 80;
        items_sent     = 0;
        quiet_cycles   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero profile: idle ticks, unused action, stop while idle,
        // then a start that falls through the phases to decel start
        send_cmd(ACT_TICK, '0);
        send_cmd(ACT_TICK, '1);
        send_cmd(ACT_UNUSED, '1);
        send_cmd(ACT_STOP, '0);
        send_cmd(ACT_START, '0);
        repeat (5) send_cmd(ACT_TICK, '1);
        send_cmd(ACT_STOP, '0);

        // extreme profile toward the most negative target: saturation
        wait_drained();
        write_reg(REG_TARGET,      32'h8000_0000);
        write_reg(REG_JERK,        32'h7FFF_FFFF);
        write_reg(REG_PEAK_ACCEL,  32'h7FFF_FFFF);
        write_reg(REG_ACC_END_VEL, 32'h7FFF_FFFF);
        write_reg(REG_PEAK_DECEL,  32'h7FFF_FFFF);
        write_reg(REG_DEC_END_VEL, 32'h0000_0000);
        write_reg(REG_DEC_DIST,    32'h7FFF_FFFF);
        cfg_write <= 1'b0;
        send_cmd(ACT_START, '1);
        repeat (7) send_cmd(ACT_TICK, '1);
        send_cmd(ACT_UNUSED, '0);
        send_cmd(ACT_START, '0);
        send_cmd(ACT_TICK, 20'd1);
        send_cmd(ACT_TICK, '0);
        send_cmd(ACT_STOP, '1);

        // random moves under three idle patterns
        items_sent = 0;
        while (items_sent < ITEMS_TOTAL / 3)
            run_motion();
        send_gap_pct   = 80;
        recv_stall_pct = 21;
        while (items_sent < 2 * ITEMS_TOTAL / 3)
            run_motion();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        while (items_sent < ITEMS_TOTAL)
            run_motion();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("jerk_limited_motion_profile_stepper regression: pass");
        else
            $display("jerk_limited_motion_profile_stepper regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/jlms_pkg.sv
rtl/jlms_time_mul.sv
rtl/jerk_limited_motion_profile_stepper.sv
tb/tb_jerk_limited_motion_profile_stepper.sv
